// File: hdl/tpse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpse_pkg
// Shared codes, constants and controller/datapath interface types of the
// tape pulse stream encoder.
// ============================================================================
package tpse_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_PULSE  = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PACKED  = 2'd0;
    localparam logic [1:0] CFG_CHANNEL = 2'd1;
    localparam logic [1:0] CFG_TABLE   = 2'd2;

    // Channel modes; any other code behaves as mono.
    localparam logic [1:0] CH_COPY   = 2'd1;
    localparam logic [1:0] CH_INVERT = 2'd2;

    localparam logic [7:0]  HIGH_SAMPLE = 8'hC0;
    localparam logic [7:0]  LOW_SAMPLE  = 8'h40;
    localparam logic [23:0] TABLE_RESET = 24'h6D2691;
    localparam logic [8:0]  ACC_EMPTY   = 9'h001;
    localparam logic [3:0]  FULL_BYTE   = 4'd8;
    localparam logic [2:0]  LAST_PULSE  = 3'd7;

    typedef struct packed {
        logic       capture;   // latch the input payload
        logic       finish;    // form the packed flush result
        logic       tick;      // run one sample tick
        logic       toggle;    // flip the level at the end of a pulse
        logic       flush;     // release the held result as the last one
        logic       single;    // pulse length comes from the pulse item
        logic [2:0] pulse_idx; // pulse number within a data byte
    } dp_cmd_t;

    typedef struct packed {
        logic       packed_mode;
        logic       tick_ok;
        logic       flush_ok;
        logic [5:0] pulse_len;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/tape_pulse_stream_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Results are held one step so that tlast is known; m_tvalid for a result rises only
// once the next result of its item forms or the item ends.
// One item at a time: the pulse sequencer takes a new item only once it is back in
// its idle state, after it is through with the pulses of the last one.
// Each pulse first loads its length in ST_LOAD; a blocked output register stalls the ticks.
// Reset: synchronous, active-low aresetn restores default registers, low level, empty packer.
// ============================================================================
// tape_pulse_stream_encoder
// Streams tape pulses and data bytes out as square-wave samples or packed bits.
// ============================================================================
module tape_pulse_stream_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] pulse_length, [15:14] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                        // [19:16] valid_bits, [23:20] zero
    output logic             m_tuser,   // [0] second_valid
    output logic             m_tlast,
    // Config write channel, always ready; must be written only while idle (unchecked).
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    tpse_pkg::dp_cmd_t  cmd;
    tpse_pkg::dp_stat_t stat;

    logic [7:0] first_byte, second_byte;
    logic [3:0] valid_bits;

    assign cfg_ready = 1'b1;

    // The controller sequences pulses and ticks; the datapath owns every
    // register that shapes the result stream.
    tpse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Results are held one step back in the datapath so that the final one
    // of each transaction can be flagged with tlast before it is released.
    tpse_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_data_byte    (s_tdata[7:0]),
        .in_pulse_length (s_tdata[13:8]),
        .cmd             (cmd),
        .stat            (stat),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_first_byte    (first_byte),
        .m_second_byte   (second_byte),
        .m_second_valid  (m_tuser),
        .m_valid_bits    (valid_bits),
        .m_tlast         (m_tlast)
    );

    assign m_tdata = {4'b0000, valid_bits, second_byte, first_byte};

endmodule
`default_nettype wire

// File: hdl/tpse_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpse_ctrl
// Sequencer that walks the pulses of an item and the ticks of each pulse.
// ============================================================================
module tpse_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        op,
    input  wire tpse_pkg::dp_stat_t stat,
    output tpse_pkg::dp_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TICK,
        ST_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] pidx_reg, pidx_next;
    logic       single_reg, single_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       pulse_done;

    always_comb begin
        state_next  = state_reg;
        pidx_next   = pidx_reg;
        single_next = single_reg;
        cnt_next    = cnt_reg;
        pulse_done  = 1'b0;
        s_tready    = 1'b0;
        cmd         = '0;
        cmd.single    = single_reg;
        cmd.pulse_idx = pidx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    unique case (op)
                        tpse_pkg::OP_DATA: begin
                            pidx_next   = '0;
                            single_next = 1'b0;
                            state_next  = ST_LOAD;
                        end
                        tpse_pkg::OP_PULSE: begin
                            single_next = 1'b1;
                            state_next  = ST_LOAD;
                        end
                        tpse_pkg::OP_FINISH: begin
                            if (stat.packed_mode) begin
                                cmd.finish = 1'b1;
                                state_next = ST_FLUSH;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                if (stat.pulse_len == '0) begin
                    cmd.toggle = 1'b1;
                    pulse_done = 1'b1;
                end else begin
                    cnt_next   = stat.pulse_len;
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                if (stat.tick_ok) begin
                    cmd.tick = 1'b1;
                    if (cnt_reg == 6'd1) begin
                        cmd.toggle = 1'b1;
                        pulse_done = 1'b1;
                    end else begin
                        cnt_next = cnt_reg - 6'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (stat.flush_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // After the last pulse of the item the held result is released.
        if (pulse_done) begin
            if (single_reg || pidx_reg == tpse_pkg::LAST_PULSE) begin
                state_next = ST_FLUSH;
            end else begin
                pidx_next  = pidx_reg + 3'd1;
                state_next = ST_LOAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pidx_reg   <= '0;
            single_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            pidx_reg   <= pidx_next;
            single_reg <= single_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/tpse_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// tpse_dp
// Level, bit packer, held result and output register of the encoder.
// ============================================================================
module tpse_dp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data,
    input  wire logic [7:0]         in_data_byte,
    input  wire logic [5:0]         in_pulse_length,
    input  wire tpse_pkg::dp_cmd_t  cmd,
    output tpse_pkg::dp_stat_t      stat,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic [7:0]              m_first_byte,
    output logic [7:0]              m_second_byte,
    output logic                    m_second_valid,
    output logic [3:0]              m_valid_bits,
    output logic                    m_tlast
);

    logic        packed_reg;
    logic [1:0]  chan_reg;
    logic [23:0] table_reg;
    logic [7:0]  data_reg;
    logic [5:0]  plen_reg;
    logic        level_reg;
    logic [8:0]  acc_reg, acc_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_first_reg, pend_first_next;
    logic [7:0]  pend_second_reg, pend_second_next;
    logic        pend_sv_reg, pend_sv_next;
    logic [3:0]  pend_vb_reg, pend_vb_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_first_reg, out_second_reg;
    logic        out_sv_reg, out_last_reg;
    logic [3:0]  out_vb_reg;

    logic        out_free, emit, out_load;
    logic [7:0]  tick_first, tick_second, sample, inv_sample;
    logic        tick_sv;
    logic [3:0]  tick_vb;
    logic [1:0]  pair;
    logic [2:0]  entry;
    logic [3:0]  marker;
    logic [8:0]  acc_norm, acc_shift;

    // Pulse length: each bit pair of the byte, high pair first, with value p gives entry p, then entry 4 + p.
    assign pair  = data_reg[{~cmd.pulse_idx[2:1], 1'b1} -: 2];
    assign entry = {cmd.pulse_idx[0], pair};

    assign stat.pulse_len = cmd.single ? plen_reg : {3'b000, table_reg[3 * entry +: 3]};

    // Tick result.
    assign sample     = level_reg ? tpse_pkg::HIGH_SAMPLE : tpse_pkg::LOW_SAMPLE;
    assign inv_sample = level_reg ? tpse_pkg::LOW_SAMPLE : tpse_pkg::HIGH_SAMPLE;

    always_comb begin
        tick_first  = sample;
        tick_second = '0;
        tick_sv     = 1'b0;
        tick_vb     = '0;
        if (packed_reg) begin
            tick_first = acc_reg[7:0];
            tick_vb    = tpse_pkg::FULL_BYTE;
        end else if (chan_reg == tpse_pkg::CH_COPY) begin
            tick_second = sample;
            tick_sv     = 1'b1;
        end else if (chan_reg == tpse_pkg::CH_INVERT) begin
            tick_second = inv_sample;
            tick_sv     = 1'b1;
        end
    end

    assign emit     = !packed_reg || acc_reg[8];
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = pend_valid_reg && ((cmd.tick && emit) || cmd.flush);

    assign stat.packed_mode = packed_reg;
    assign stat.tick_ok     = !(emit && pend_valid_reg && !out_free);
    assign stat.flush_ok    = !pend_valid_reg || out_free;

    // Flush: the marker position is the number of bits held.
    always_comb begin
        acc_norm = (acc_reg == '0) ? tpse_pkg::ACC_EMPTY : acc_reg;
        marker   = '0;
        for (int i = 1; i < 9; i++) begin
            if (acc_norm[i]) begin
                marker = 4'(i);
            end
        end
        acc_shift = acc_norm << (tpse_pkg::FULL_BYTE - marker);
    end

    always_comb begin
        acc_next         = acc_reg;
        pend_valid_next  = pend_valid_reg;
        pend_first_next  = pend_first_reg;
        pend_second_next = pend_second_reg;
        pend_sv_next     = pend_sv_reg;
        pend_vb_next     = pend_vb_reg;

        if (cmd.tick && packed_reg) begin
            if (acc_reg[8]) begin
                acc_next = {7'b0000000, 1'b1, level_reg};
            end else begin
                acc_next = {acc_reg[7:0], level_reg};
            end
        end
        if (cmd.tick && emit) begin
            pend_valid_next  = 1'b1;
            pend_first_next  = tick_first;
            pend_second_next = tick_second;
            pend_sv_next     = tick_sv;
            pend_vb_next     = tick_vb;
        end
        if (cmd.finish) begin
            acc_next         = tpse_pkg::ACC_EMPTY;
            pend_valid_next  = 1'b1;
            pend_first_next  = acc_shift[7:0];
            pend_second_next = '0;
            pend_sv_next     = 1'b0;
            pend_vb_next     = marker;
        end
        if (cmd.flush) begin
            pend_valid_next = 1'b0;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packed_reg     <= 1'b0;
            chan_reg       <= '0;
            table_reg      <= tpse_pkg::TABLE_RESET;
            level_reg      <= 1'b0;
            acc_reg        <= tpse_pkg::ACC_EMPTY;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    tpse_pkg::CFG_PACKED:  packed_reg <= cfg_data[0];
                    tpse_pkg::CFG_CHANNEL: chan_reg   <= cfg_data[1:0];
                    tpse_pkg::CFG_TABLE:   table_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.toggle) begin
                level_reg <= ~level_reg;
            end
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            data_reg <= in_data_byte;
            plen_reg <= in_pulse_length;
        end
        pend_first_reg  <= pend_first_next;
        pend_second_reg <= pend_second_next;
        pend_sv_reg     <= pend_sv_next;
        pend_vb_reg     <= pend_vb_next;
        if (out_load) begin
            out_first_reg  <= pend_first_reg;
            out_second_reg <= pend_second_reg;
            out_sv_reg     <= pend_sv_reg;
            out_vb_reg     <= pend_vb_reg;
            out_last_reg   <= cmd.flush;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_first_byte   = out_first_reg;
    assign m_second_byte  = out_second_reg;
    assign m_second_valid = out_sv_reg;
    assign m_valid_bits   = out_vb_reg;
    assign m_tlast        = out_last_reg;

endmodule
`default_nettype wire
